// ----- hw/rtl/nda_pkg.sv -----
package nda_pkg;

   localparam int DATA_W = 16;
   localparam int ACC_W = 44;
   localparam int PROD_W = 32;
   localparam int XC_W = 28;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   localparam longint Q24_EIGHT = 64'sd134217728;
   localparam longint unsigned E_INV_Q32 = 64'd1580030169;
   localparam longint unsigned ONE_Q32 = 64'd1 << 32;

   typedef logic signed [DATA_W-1:0] q412_type;
   typedef logic [DATA_W-1:0] q115_type;
   typedef logic signed [ACC_W-1:0] acc_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic [XC_W-1:0] offset_type;

   typedef enum logic {
      ACT_SIGMOID = 1'b0,
      ACT_RADIAL  = 1'b1
   } act_mode_type;

   // unsigned 64-bit quotient by shift and subtract
   function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
      logic [64:0] rem;
      longint unsigned quo;
      int b;
      rem = '0;
      quo = '0;
      for (b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // e^-t, t unsigned Q.24, result Q.32
   function automatic longint unsigned exp_neg_q32(longint unsigned t24);
      longint unsigned n;
      longint unsigned f;
      longint unsigned term;
      longint unsigned sum;
      longint unsigned v;
      longint unsigned i;
      longint unsigned k;
      n = t24 >> 24;
      f = (t24 & 64'hFF_FFFF) << 8;
      term = ONE_Q32;
      sum = ONE_Q32;
      for (k = 1; k <= 13; k++) begin
         term = div_u64((term * f) >> 32, k);
         sum = sum + term;
      end
      v = div_u64(64'hFFFF_FFFF_FFFF_FFFF, sum);
      for (i = 0; i < n && v != 0; i++) begin
         v = (v * E_INV_Q32) >> 32;
      end
      return v;
   endfunction

   // activation at x (signed Q.24, |x| <= 8), result Q1.15
   function automatic q115_type act_at(act_mode_type mode, longint x);
      longint unsigned ax;
      longint unsigned e;
      longint unsigned d;
      longint unsigned num;
      longint unsigned sq;
      longint unsigned r;
      ax = (x < 0) ? longint'(-x) : longint'(x);
      if (mode == ACT_SIGMOID) begin
         e = exp_neg_q32(ax);
         d = ONE_Q32 + e;
         num = (x >= 0) ? (64'd1 << 47) : (e << 15);
         r = div_u64(num + (d >> 1), d);
      end else begin
         sq = (ax * ax + (64'd1 << 23)) >> 24;
         r = (exp_neg_q32(sq) + (64'd1 << 16)) >> 17;
         if (r > 64'd32768) begin
            r = 64'd32768;
         end
      end
      return r[DATA_W-1:0];
   endfunction

endpackage

// ----- hw/rtl/nda_if.sv -----
interface nda_req_if;
   import nda_pkg::*;
   logic valid;
   logic ready;
   q412_type input_value;
   q412_type weight_value;
   logic is_bias;
   logic no_weights;
   modport source(output valid, output input_value, output weight_value,
                  output is_bias, output no_weights, input ready);
   modport sink(input valid, input input_value, input weight_value,
                input is_bias, input no_weights, output ready);
endinterface

interface nda_rsp_if;
   import nda_pkg::*;
   logic valid;
   logic ready;
   q115_type activation_out;
   logic sum_clamped;
   modport source(output valid, output activation_out, output sum_clamped, input ready);
   modport sink(input valid, input activation_out, input sum_clamped, output ready);
endinterface

interface nda_csr_if;
   logic valid;
   logic ready;
   logic activation_mode;
   modport source(output valid, output activation_mode, input ready);
   modport sink(input valid, input activation_mode, output ready);
endinterface

// ----- hw/rtl/neuron_dot_product_activation.sv -----
// A bias request passes the input register, stages s1 to s5 and the output register before its result shows on rsp_bus.
// Throughput: 1 request per cycle; the pipeline halts only while a finished result
// sits in the output register untaken and the next result has reached the last stage.
// Reset: synchronous, active high; clears all valid bits, the running sum and the
// activation mode (sigmoid). TABLE_SEGMENTS must be a power of two.
module neuron_dot_product_activation #(
   parameter int TABLE_SEGMENTS = 64
) (
   input logic clock,
   input logic reset,
   nda_req_if.sink req_bus,
   nda_rsp_if.source rsp_bus,
   nda_csr_if.sink csr_bus
);
   import nda_pkg::*;

   localparam int SEG_BITS = $clog2(TABLE_SEGMENTS);
   localparam int FRAC_W = XC_W - SEG_BITS;
   localparam int WT_W = FRAC_W + 1;
   localparam int MUL_W = DATA_W + WT_W;
   localparam int TOT_W = MUL_W + 1;
   localparam int ADDR_W = SEG_BITS + 1;
   localparam logic [WT_W-1:0] SEG_SPAN = WT_W'(1) << FRAC_W;
   localparam logic [TOT_W-1:0] SEG_HALF = TOT_W'(1) << (FRAC_W - 1);

   // breakpoint tables, addressed by {mode, segment}
   q115_type y_lo_tab [2*TABLE_SEGMENTS];
   q115_type y_hi_tab [2*TABLE_SEGMENTS];

   for (genvar gm = 0; gm < 2; gm++) begin : g_mode
      for (genvar gk = 0; gk < TABLE_SEGMENTS; gk++) begin : g_seg
         localparam longint X_LO = (longint'(gk) <<< FRAC_W) - Q24_EIGHT;
         localparam longint X_HI = (longint'(gk + 1) <<< FRAC_W) - Q24_EIGHT;
         localparam q115_type Y_LO = act_at(act_mode_type'(gm), X_LO);
         localparam q115_type Y_HI = act_at(act_mode_type'(gm), X_HI);
         assign y_lo_tab[gm*TABLE_SEGMENTS+gk] = Y_LO;
         assign y_hi_tab[gm*TABLE_SEGMENTS+gk] = Y_HI;
      end
   end

   act_mode_type mode_ff;

   logic advance;

   logic s0_valid_ff;
   q412_type s0_input_ff;
   q412_type s0_weight_ff;
   logic s0_bias_ff;
   logic s0_nowt_ff;

   logic s1_valid_ff;
   prod_type s1_prod_ff;
   prod_type s1_prod_in;
   logic s1_bias_ff;
   logic s1_nowt_ff;

   acc_type acc_ff;
   logic [ACC_W:0] acc_wide;
   acc_type acc_sat;

   logic s2_valid_ff;
   acc_type s2_sum_ff;
   logic s2_nowt_ff;

   logic s3_valid_ff;
   offset_type s3_off_ff;
   offset_type s3_off_in;
   logic s3_clamped_ff;
   logic s3_clamped_in;
   logic s3_nowt_ff;
   logic in_range;

   logic s4_valid_ff;
   q115_type s4_y_lo_ff;
   q115_type s4_y_hi_ff;
   logic [FRAC_W-1:0] s4_w_ff;
   logic s4_clamped_ff;
   logic s4_nowt_ff;
   logic [ADDR_W-1:0] rom_addr;

   logic s5_valid_ff;
   logic [MUL_W-1:0] s5_p_lo_ff;
   logic [MUL_W-1:0] s5_p_hi_ff;
   logic s5_clamped_ff;
   logic s5_nowt_ff;

   logic [TOT_W-1:0] total;

   logic rsp_valid_ff;
   logic rsp_valid_in;
   q115_type rsp_act_ff;
   logic rsp_clamped_ff;

   assign advance = !(s5_valid_ff && rsp_valid_ff && !rsp_bus.ready);
   assign req_bus.ready = advance;
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ACT_SIGMOID;
      end else if (csr_bus.valid) begin
         mode_ff <= act_mode_type'(csr_bus.activation_mode);
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_bus.valid;
      end
      if (advance) begin
         s0_input_ff <= req_bus.input_value;
         s0_weight_ff <= req_bus.weight_value;
         s0_bias_ff <= req_bus.is_bias;
         s0_nowt_ff <= req_bus.no_weights;
      end
   end

   // product, or bias scaled to Q.24
   always_comb begin
      if (s0_bias_ff) begin
         s1_prod_in = {{(PROD_W-DATA_W-12){s0_weight_ff[DATA_W-1]}}, s0_weight_ff, 12'd0};
      end else begin
         s1_prod_in = prod_type'(s0_input_ff) * prod_type'(s0_weight_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s0_valid_ff;
      end
      if (advance) begin
         s1_prod_ff <= s1_prod_in;
         s1_bias_ff <= s0_bias_ff;
         s1_nowt_ff <= s0_nowt_ff;
      end
   end

   // saturating accumulate
   always_comb begin
      acc_wide = {acc_ff[ACC_W-1], acc_ff}
               + {{(ACC_W+1-PROD_W){s1_prod_ff[PROD_W-1]}}, s1_prod_ff};
      if (acc_wide[ACC_W] != acc_wide[ACC_W-1]) begin
         acc_sat = acc_wide[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
         acc_sat = acc_wide[ACC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff && s1_bias_ff;
         if (s1_valid_ff) begin
            acc_ff <= s1_bias_ff ? acc_type'(0) : acc_sat;
         end
      end
      if (advance) begin
         s2_sum_ff <= acc_sat;
         s2_nowt_ff <= s1_nowt_ff;
      end
   end

   // clamp to [-8, 8) and offset to [0, 2^28)
   always_comb begin
      in_range = (&s2_sum_ff[ACC_W-1:XC_W-1]) || !(|s2_sum_ff[ACC_W-1:XC_W-1]);
      if (in_range) begin
         s3_off_in = {~s2_sum_ff[XC_W-1], s2_sum_ff[XC_W-2:0]};
         s3_clamped_in = 1'b0;
      end else begin
         s3_off_in = s2_sum_ff[ACC_W-1] ? '0 : '1;
         s3_clamped_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (advance) begin
         s3_off_ff <= s3_off_in;
         s3_clamped_ff <= s3_clamped_in;
         s3_nowt_ff <= s2_nowt_ff;
      end
   end

   // table read
   assign rom_addr = {mode_ff, s3_off_ff[XC_W-1 -: SEG_BITS]};

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (advance) begin
         s4_y_lo_ff <= y_lo_tab[rom_addr];
         s4_y_hi_ff <= y_hi_tab[rom_addr];
         s4_w_ff <= s3_off_ff[FRAC_W-1:0];
         s4_clamped_ff <= s3_clamped_ff;
         s4_nowt_ff <= s3_nowt_ff;
      end
   end

   // weighted interpolation products
   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s5_valid_ff <= s4_valid_ff;
      end
      if (advance) begin
         s5_p_lo_ff <= MUL_W'(s4_y_lo_ff) * MUL_W'(SEG_SPAN - WT_W'(s4_w_ff));
         s5_p_hi_ff <= MUL_W'(s4_y_hi_ff) * MUL_W'(s4_w_ff);
         s5_clamped_ff <= s4_clamped_ff;
         s5_nowt_ff <= s4_nowt_ff;
      end
   end

   assign total = TOT_W'(s5_p_lo_ff) + TOT_W'(s5_p_hi_ff) + SEG_HALF;

   // output register
   assign rsp_valid_in = (advance && s5_valid_ff) || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance && s5_valid_ff) begin
         rsp_act_ff <= s5_nowt_ff ? q115_type'(0) : total[FRAC_W +: DATA_W];
         rsp_clamped_ff <= s5_clamped_ff && !s5_nowt_ff;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.activation_out = rsp_act_ff;
   assign rsp_bus.sum_clamped = rsp_clamped_ff;

endmodule
